// ===== sv/can_tx_backoff_supervisor_assert.svh =====
// Assertion macros shared by the supervisor RTL.
`ifndef CAN_TX_BACKOFF_SUPERVISOR_ASSERT_SVH
`define CAN_TX_BACKOFF_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CTB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CTB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cantxb_pkg.sv =====
// Types, codes and reset values of the CAN transmit backoff supervisor.
package cantxb_pkg;

	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned CfgDataW  = 16;

	localparam logic [CfgIndexW-1:0] CFG_ONLINE         = 3'd0;
	localparam logic [CfgIndexW-1:0] CFG_POLL_PERIOD    = 3'd1;
	localparam logic [CfgIndexW-1:0] CFG_TX_TIMEOUT     = 3'd2;
	localparam logic [CfgIndexW-1:0] CFG_BACKOFF_INIT   = 3'd3;
	localparam logic [CfgIndexW-1:0] CFG_BACKOFF_MAX    = 3'd4;

	localparam logic        RST_ONLINE       = 1'b1;
	localparam logic [7:0]  RST_POLL_PERIOD  = 8'd2;
	localparam logic [15:0] RST_TX_TIMEOUT   = 16'd20;
	localparam logic [15:0] RST_BACKOFF_INIT = 16'd1000;
	localparam logic [15:0] RST_BACKOFF_MAX  = 16'd10000;

	localparam logic KIND_SEND = 1'b0;
	localparam logic KIND_POLL = 1'b1;

	typedef enum logic [2:0] {
		OUT_NONE      = 3'd0,
		OUT_DROPPED   = 3'd1,
		OUT_QUEUED    = 3'd2,
		OUT_FAILED    = 3'd3,
		OUT_CONFIRMED = 3'd4
	} outcome_t;

	typedef struct packed {
		logic        online;
		logic [7:0]  poll_period_ms;
		logic [15:0] tx_timeout_ms;
		logic [15:0] backoff_initial_ms;
		logic [15:0] backoff_max_ms;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] now_ms;
		logic        txreq_busy;
		logic        queue_ok;
		logic        bus_off_flag;
		logic        rx_overflow;
		logic [2:0]  tx_error_flags;
	} item_t;

	typedef struct packed {
		logic        tx_pending;
		logic        bus_off;
		logic [15:0] retry_delay;
		logic [31:0] last_failure_time;
		logic [31:0] tx_start_time;
		logic [31:0] last_poll_time;
	} state_t;

	localparam state_t STATE_RESET = '{
		tx_pending:        1'b0,
		bus_off:           1'b0,
		retry_delay:       16'd0,
		last_failure_time: 32'd0,
		tx_start_time:     32'd0,
		last_poll_time:    32'd0
	};

	typedef struct packed {
		logic        abort_transmit;
		logic        start_transmit;
		logic        clear_overflow;
		outcome_t    tx_outcome;
		logic [15:0] backoff_ms;
		logic        pending_now;
		logic        bus_off_now;
	} result_t;

endpackage

// ===== sv/cantxb_eval.sv =====
// Decision logic: next supervisor state and result for one item.
module cantxb_eval (
	input  cantxb_pkg::cfg_t    cfg,
	input  cantxb_pkg::state_t  cur,
	input  cantxb_pkg::item_t   item,
	output cantxb_pkg::state_t  nxt,
	output cantxb_pkg::result_t res
);

	logic [31:0] since_fail;
	logic [31:0] since_poll;
	logic [31:0] since_start;
	logic        backing;
	logic        poll_ok;
	logic        bus_off_entry;
	logic [16:0] doubled;
	logic [15:0] capped;
	logic [15:0] backoff_next;
	logic        fail;

	assign since_fail  = item.now_ms - cur.last_failure_time;
	assign since_poll  = item.now_ms - cur.last_poll_time;
	assign since_start = item.now_ms - cur.tx_start_time;

	assign backing = (cur.retry_delay != 16'd0) && (since_fail < {16'd0, cur.retry_delay});
	assign poll_ok = cfg.online && (since_poll >= {24'd0, cfg.poll_period_ms});
	assign bus_off_entry = item.bus_off_flag && !cur.bus_off;

	// Doubling saturates at the cap; the first failure takes the initial value as is.
	assign doubled = {cur.retry_delay, 1'b0};
	assign capped  = (doubled > {1'b0, cfg.backoff_max_ms}) ? cfg.backoff_max_ms
		: doubled[15:0];
	assign backoff_next = (cur.retry_delay == 16'd0) ? cfg.backoff_initial_ms : capped;

	always_comb begin
		nxt                = cur;
		res.abort_transmit = 1'b0;
		res.start_transmit = 1'b0;
		res.clear_overflow = 1'b0;
		res.tx_outcome     = cantxb_pkg::OUT_NONE;
		fail               = 1'b0;

		if (item.kind == cantxb_pkg::KIND_SEND) begin
			if (!cfg.online || cur.bus_off || cur.tx_pending || backing) begin
				res.tx_outcome = cantxb_pkg::OUT_DROPPED;
			end else if (item.txreq_busy || !item.queue_ok) begin
				res.abort_transmit = 1'b1;
				fail               = 1'b1;
				res.tx_outcome     = cantxb_pkg::OUT_FAILED;
			end else begin
				res.start_transmit = 1'b1;
				nxt.tx_pending     = 1'b1;
				nxt.tx_start_time  = item.now_ms;
				res.tx_outcome     = cantxb_pkg::OUT_QUEUED;
			end
		end else if (poll_ok) begin
			nxt.last_poll_time = item.now_ms;
			nxt.bus_off        = item.bus_off_flag;
			res.clear_overflow = item.rx_overflow;
			if (bus_off_entry) begin
				// entry into bus-off kills the pending transmit, no further check
				res.abort_transmit = 1'b1;
				fail               = 1'b1;
				res.tx_outcome     = cantxb_pkg::OUT_FAILED;
			end else if (cur.tx_pending) begin
				if (item.txreq_busy) begin
					if (since_start >= {16'd0, cfg.tx_timeout_ms}) begin
						res.abort_transmit = 1'b1;
						fail               = 1'b1;
						res.tx_outcome     = cantxb_pkg::OUT_FAILED;
					end
				end else begin
					nxt.tx_pending = 1'b0;
					if (item.tx_error_flags != 3'd0) begin
						fail           = 1'b1;
						res.tx_outcome = cantxb_pkg::OUT_FAILED;
					end else begin
						nxt.retry_delay = 16'd0;
						res.tx_outcome  = cantxb_pkg::OUT_CONFIRMED;
					end
				end
			end
		end

		if (fail) begin
			nxt.retry_delay       = backoff_next;
			nxt.last_failure_time = item.now_ms;
			nxt.tx_pending        = 1'b0;
		end

		res.backoff_ms  = nxt.retry_delay;
		res.pending_now = nxt.tx_pending;
		res.bus_off_now = nxt.bus_off;
	end

endmodule

// ===== sv/can_tx_backoff_supervisor.sv =====
// Top level of the CAN transmit backoff supervisor.
//
//  channel | direction | handshake          | payload
//  in      | into      | in_valid/in_stall  | kind, now_ms, txreq_busy, queue_ok,
//          |           |                    | bus_off_flag, rx_overflow, tx_error_flags
//  out     | out of    | out_valid/out_stall| abort_transmit, start_transmit, clear_overflow,
//          |           |                    | tx_outcome, backoff_ms, pending_now, bus_off_now
//  cfg     | into      | cfg_we             | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled. The result is registered
// (input register, then result register), set by the single decision stage.
// Supervisor state updates as the item moves into the result register.
// Reset restores register defaults and clears all state; no clearing pass.
// A stalled output holds the result; the input register still takes a transfer
// whenever the result register frees up in the same cycle.
module can_tx_backoff_supervisor (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [31:0]                         now_ms,
	input  logic                                txreq_busy,
	input  logic                                queue_ok,
	input  logic                                bus_off_flag,
	input  logic                                rx_overflow,
	input  logic [2:0]                          tx_error_flags,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                abort_transmit,
	output logic                                start_transmit,
	output logic                                clear_overflow,
	output logic [2:0]                          tx_outcome,
	output logic [15:0]                         backoff_ms,
	output logic                                pending_now,
	output logic                                bus_off_now,

	input  logic                                cfg_we,
	input  logic [cantxb_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [cantxb_pkg::CfgDataW-1:0]     cfg_data
);

	`include "can_tx_backoff_supervisor_assert.svh"

	cantxb_pkg::cfg_t    cfg_q;
	cantxb_pkg::state_t  state_q;
	cantxb_pkg::state_t  state_nxt;
	cantxb_pkg::item_t   item_s1;
	logic                valid_s1;
	cantxb_pkg::result_t res_nxt;
	cantxb_pkg::result_t res_q;
	logic                out_valid_q;
	logic                accept_in;
	logic                out_free;
	logic                advance;

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign accept_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.online             <= cantxb_pkg::RST_ONLINE;
			cfg_q.poll_period_ms     <= cantxb_pkg::RST_POLL_PERIOD;
			cfg_q.tx_timeout_ms      <= cantxb_pkg::RST_TX_TIMEOUT;
			cfg_q.backoff_initial_ms <= cantxb_pkg::RST_BACKOFF_INIT;
			cfg_q.backoff_max_ms     <= cantxb_pkg::RST_BACKOFF_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cantxb_pkg::CFG_ONLINE:       cfg_q.online             <= cfg_data[0];
				cantxb_pkg::CFG_POLL_PERIOD:  cfg_q.poll_period_ms     <= cfg_data[7:0];
				cantxb_pkg::CFG_TX_TIMEOUT:   cfg_q.tx_timeout_ms      <= cfg_data;
				cantxb_pkg::CFG_BACKOFF_INIT: cfg_q.backoff_initial_ms <= cfg_data;
				cantxb_pkg::CFG_BACKOFF_MAX:  cfg_q.backoff_max_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			item_s1 <= '{
				kind:           kind,
				now_ms:         now_ms,
				txreq_busy:     txreq_busy,
				queue_ok:       queue_ok,
				bus_off_flag:   bus_off_flag,
				rx_overflow:    rx_overflow,
				tx_error_flags: tx_error_flags
			};
		end
	end

	cantxb_eval u_eval (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// commit state together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cantxb_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign abort_transmit = res_q.abort_transmit;
	assign start_transmit = res_q.start_transmit;
	assign clear_overflow = res_q.clear_overflow;
	assign tx_outcome     = res_q.tx_outcome;
	assign backoff_ms     = res_q.backoff_ms;
	assign pending_now    = res_q.pending_now;
	assign bus_off_now    = res_q.bus_off_now;

	`CTB_ASSERT_IMP(a_no_pending_in_bus_off, 1'b1, !(state_q.tx_pending && state_q.bus_off), "transmit pending while bus-off")
	`CTB_ASSERT_NXT(a_queued_sets_pending, advance && (res_nxt.tx_outcome == cantxb_pkg::OUT_QUEUED), state_q.tx_pending, "queued item left no pending transmit")
	`CTB_ASSERT_IMP(a_start_abort_excl, out_valid_q, !(res_q.start_transmit && res_q.abort_transmit), "start and abort in one result")
	`CTB_ASSERT_IMP(a_stall_needs_item, in_stall, valid_s1 && out_valid_q, "input stalled with no blocking result")

endmodule
